>>> src/rk4q_pkg.sv
// shared types, constants and saturating arithmetic for the rk4 quadratic integrator
`timescale 1ns / 1ps

package rk4q_pkg;

  localparam int LANES      = 4;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 24;
  localparam int DT_BITS    = 31;
  localparam int STEP_BITS  = 16;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;
  localparam int SIXTH_BIAS = 3;
  // ceil(2^34 / 6): product shifted right by 34 is the exact n / 6 for any 32-bit n
  localparam logic [VALUE_BITS-1:0] SIXTH_RECIP = 32'hAAAA_AAAB;
  localparam int SIXTH_SHIFT = 34;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_INITIAL_VALUE,
    CFG_STEP_SIZE,
    CFG_STEP_COUNT
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_DONE
  } state_t;

  // one rk4 step: k1, trial 2, k2, trial 3, k3, trial 4, k4, new x
  typedef enum logic [2:0] {
    PH_K1,
    PH_T2,
    PH_K2,
    PH_T3,
    PH_K3,
    PH_T4,
    PH_K4,
    PH_X
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   mul;
    logic   post;
    phase_t phase;
  } lane_ctrl_t;

  typedef struct packed {
    value_t param_lane0;
    value_t param_lane1;
    value_t param_lane2;
    value_t param_lane3;
  } in_item_t;

  typedef struct packed {
    value_t final_lane0;
    value_t final_lane1;
    value_t final_lane2;
    value_t final_lane3;
  } out_item_t;

  typedef struct packed {
    cfg_index_t             index;
    logic [VALUE_BITS-1:0]  data;
  } cfg_wr_t;

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end
    return s[VALUE_BITS-1:0];
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end
    return s[VALUE_BITS-1:0];
  endfunction

  // round half up, floor shift, clamp to the value range
  function automatic value_t qround(input prod_t prod);
    prod_t                     r;
    logic [QUOT_BITS-1:0]      t;
    r = prod + (prod_t'(1) <<< (FRAC_BITS - 1));
    t = r[PROD_BITS-1:FRAC_BITS];
    if (t[QUOT_BITS-1:VALUE_BITS-1] == '0 || t[QUOT_BITS-1:VALUE_BITS-1] == '1) begin
      return t[VALUE_BITS-1:0];
    end
    return t[QUOT_BITS-1] ? VAL_MIN : VAL_MAX;
  endfunction

endpackage

>>> src/rk4q_stream_if.sv
// valid/ready channel carrying one payload item per transfer
`timescale 1ns / 1ps

interface rk4q_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/rk4q_lane.sv
// one integration lane: shared-multiplier rk4 datapath for dx/dt = x*x - p
`timescale 1ns / 1ps

module rk4q_lane (
  input  logic                clk,
  input  rk4q_pkg::lane_ctrl_t ctrl,
  input  rk4q_pkg::value_t    param,
  input  rk4q_pkg::value_t    init_value,
  input  rk4q_pkg::value_t    half_step,
  input  rk4q_pkg::value_t    full_step,
  input  rk4q_pkg::value_t    sixth_step,
  output rk4q_pkg::value_t    x_out
);

  rk4q_pkg::value_t p;
  rk4q_pkg::value_t x;
  rk4q_pkg::value_t trial;
  rk4q_pkg::value_t k;
  rk4q_pkg::value_t sum;
  rk4q_pkg::prod_t  prod;

  rk4q_pkg::value_t mul_a;
  rk4q_pkg::value_t mul_b;
  rk4q_pkg::value_t q;
  rk4q_pkg::value_t k_new;

  always_comb begin
    q     = rk4q_pkg::qround(prod);
    k_new = rk4q_pkg::sat_sub(q, p);
    mul_a = x;
    mul_b = x;
    case (ctrl.phase) inside
      rk4q_pkg::PH_K1: begin
        mul_a = x;
        mul_b = x;
      end
      rk4q_pkg::PH_T2, rk4q_pkg::PH_T3: begin
        mul_a = half_step;
        mul_b = k;
      end
      rk4q_pkg::PH_T4: begin
        mul_a = full_step;
        mul_b = k;
      end
      rk4q_pkg::PH_K2, rk4q_pkg::PH_K3, rk4q_pkg::PH_K4: begin
        mul_a = trial;
        mul_b = trial;
      end
      default: begin
        mul_a = sum;
        mul_b = sixth_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p <= param;
      x <= init_value;
    end else if (ctrl.mul) begin
      prod <= mul_a * mul_b;
    end else if (ctrl.post) begin
      case (ctrl.phase) inside
        rk4q_pkg::PH_K1: begin
          k   <= k_new;
          sum <= k_new;
        end
        rk4q_pkg::PH_T2, rk4q_pkg::PH_T3, rk4q_pkg::PH_T4: begin
          trial <= rk4q_pkg::sat_add(x, q);
        end
        rk4q_pkg::PH_K2, rk4q_pkg::PH_K3: begin
          k   <= k_new;
          sum <= rk4q_pkg::sat_add(sum, rk4q_pkg::sat_add(k_new, k_new));
        end
        rk4q_pkg::PH_K4: begin
          sum <= rk4q_pkg::sat_add(sum, k_new);
        end
        default: begin
          x <= rk4q_pkg::sat_add(x, q);
        end
      endcase
    end
  end

  assign x_out = x;

endmodule

>>> src/rk4q_seq.sv
// step sequencer: dt/6 reciprocal, phase and step counters, lane control
`timescale 1ns / 1ps

module rk4q_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [rk4q_pkg::DT_BITS-1:0]         step_size,
  input  logic [rk4q_pkg::STEP_BITS-1:0]       step_count,
  input  logic                                 out_free,
  output logic                                 idle,
  output logic                                 done,
  output logic [rk4q_pkg::VALUE_BITS-1:0]      sixth,
  output rk4q_pkg::lane_ctrl_t                 ctrl
);

  rk4q_pkg::state_t                        state, state_next;
  logic [rk4q_pkg::VALUE_BITS-1:0]         numer, numer_next;
  logic [rk4q_pkg::PROD_BITS-1:0]          recip_prod;
  rk4q_pkg::phase_t                        phase, phase_next;
  logic                                    sub, sub_next;
  logic [rk4q_pkg::STEP_BITS-1:0]          steps, steps_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rk4q_pkg::S_IDLE;
      phase <= rk4q_pkg::PH_K1;
      sub   <= 1'b0;
      steps <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      sub   <= sub_next;
      steps <= steps_next;
    end
  end

  always_ff @(posedge clk) begin
    numer <= numer_next;
  end

  always_comb begin
    state_next = state;
    numer_next = numer;
    phase_next = phase;
    sub_next   = sub;
    steps_next = steps;
    idle       = 1'b0;
    done       = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.mul   = 1'b0;
    ctrl.post  = 1'b0;
    ctrl.phase = phase;
    recip_prod = numer * rk4q_pkg::SIXTH_RECIP;
    unique case (state)
      rk4q_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          ctrl.load  = 1'b1;
          numer_next = {1'b0, step_size} + rk4q_pkg::VALUE_BITS'(rk4q_pkg::SIXTH_BIAS);
          state_next = rk4q_pkg::S_PREP;
        end
      end
      rk4q_pkg::S_PREP: begin
        // division by six through the reciprocal product
        numer_next = rk4q_pkg::VALUE_BITS'(
          recip_prod[rk4q_pkg::PROD_BITS-1:rk4q_pkg::SIXTH_SHIFT]);
        phase_next = rk4q_pkg::PH_K1;
        sub_next   = 1'b0;
        steps_next = '0;
        state_next = (step_count == '0) ? rk4q_pkg::S_DONE : rk4q_pkg::S_RUN;
      end
      rk4q_pkg::S_RUN: begin
        ctrl.mul  = !sub;
        ctrl.post = sub;
        sub_next  = !sub;
        if (sub) begin
          phase_next = rk4q_pkg::phase_t'(phase + 3'd1);
          if (phase == rk4q_pkg::PH_X) begin
            steps_next = steps + 1'b1;
            if (steps + 1'b1 == step_count) begin
              state_next = rk4q_pkg::S_DONE;
            end
          end
        end
      end
      rk4q_pkg::S_DONE: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = rk4q_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rk4q_pkg::S_IDLE;
      end
    endcase
  end

  assign sixth = numer;

endmodule

>>> src/rk4_quadratic_ode_integrator_top.sv
// Four-lane fixed-step RK4 integrator for dx/dt = x*x - p in signed Q8.24.
// Channels: cfg takes register writes (index 0 initial value, 1 step size,
// 2 step count) and is always ready; params carries one p per lane; finals
// returns the four final x values, one transfer per params transfer.
// After a params transfer, the prep state forms dt/6 with a reciprocal
// multiplication; each rk4 step then runs eight dependent multiplications
// on the one multiplier each lane owns, each as operand select and
// multiply, then round and update, and the result lands in the output
// register. params is ready only while no item is in flight, so a new
// item is accepted only after the last one has finished.
// The output register frees the datapath: a new item is accepted while an
// earlier result still waits. A finished item waits in place if the output
// register is still full when the receiver stalls.
// Reset (rst, synchronous, active high) restores the register defaults
// (x0 = -0.5, dt = 0.01, 1000 steps) and drops any item in flight.
`timescale 1ns / 1ps

module rk4_quadratic_ode_integrator_top (
  input  logic           clk,
  input  logic           rst,
  rk4q_stream_if.sink    cfg,
  rk4q_stream_if.sink    params,
  rk4q_stream_if.source  finals
);

  rk4q_pkg::value_t                      initial_value;
  logic [rk4q_pkg::DT_BITS-1:0]          step_size;
  logic [rk4q_pkg::STEP_BITS-1:0]        step_count;

  rk4q_pkg::value_t                      param_arr [rk4q_pkg::LANES];
  rk4q_pkg::value_t                      lane_x [rk4q_pkg::LANES];
  rk4q_pkg::value_t                      half_step;
  rk4q_pkg::value_t                      full_step;
  logic [rk4q_pkg::VALUE_BITS-1:0]       sixth;
  rk4q_pkg::lane_ctrl_t                  ctrl;
  rk4q_pkg::cfg_wr_t                     cfg_wr;
  rk4q_pkg::in_item_t                    in_item;
  rk4q_pkg::out_item_t                   out_item;
  logic                                  out_valid;
  logic                                  out_free;
  logic                                  idle;
  logic                                  done;
  logic                                  start;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= -rk4q_pkg::value_t'(8388608);
      step_size     <= rk4q_pkg::DT_BITS'(167772);
      step_count    <= rk4q_pkg::STEP_BITS'(1000);
    end else if (cfg.valid) begin
      unique case (cfg_wr.index)
        rk4q_pkg::CFG_INITIAL_VALUE: initial_value <= cfg_wr.data;
        rk4q_pkg::CFG_STEP_SIZE:     step_size <= cfg_wr.data[rk4q_pkg::DT_BITS-1:0];
        rk4q_pkg::CFG_STEP_COUNT:    step_count <= cfg_wr.data[rk4q_pkg::STEP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item      = params.payload;
  assign params.ready = idle;
  assign start        = params.valid && idle;

  assign param_arr[0] = in_item.param_lane0;
  assign param_arr[1] = in_item.param_lane1;
  assign param_arr[2] = in_item.param_lane2;
  assign param_arr[3] = in_item.param_lane3;

  assign full_step = {1'b0, step_size};
  assign half_step = ({1'b0, step_size} + rk4q_pkg::VALUE_BITS'(1)) >> 1;

  rk4q_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .step_size  (step_size),
    .step_count (step_count),
    .out_free   (out_free),
    .idle       (idle),
    .done       (done),
    .sixth      (sixth),
    .ctrl       (ctrl)
  );

  for (genvar i = 0; i < rk4q_pkg::LANES; i++) begin : g_lane
    rk4q_lane u_lane (
      .clk        (clk),
      .ctrl       (ctrl),
      .param      (param_arr[i]),
      .init_value (initial_value),
      .half_step  (half_step),
      .full_step  (full_step),
      .sixth_step (sixth),
      .x_out      (lane_x[i])
    );
  end

  // merge the lanes into the output register
  assign out_free = !out_valid || finals.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (finals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_item.final_lane0 <= lane_x[0];
      out_item.final_lane1 <= lane_x[1];
      out_item.final_lane2 <= lane_x[2];
      out_item.final_lane3 <= lane_x[3];
    end
  end

  assign finals.valid   = out_valid;
  assign finals.payload = out_item;

endmodule
